@@ rtl/core/bcq_pkg.sv @@
`timescale 1ns / 1ps

package bcq_pkg;

	// bucket field width, fixed by the item format
	localparam int unsigned BUCKET_W = 13;

	// wide enough for two caches, the last entry and the deepest ring
	localparam int unsigned OCC_W = 9;

	localparam int unsigned BUCKET_COUNT_DEF  = 8192;
	localparam int unsigned RING_DEPTH_DEF    = 32;
	localparam int unsigned PAYLOAD_WIDTH_DEF = 32;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_STEP   = 2'd1;
	localparam logic [1:0] CMD_UNLOCK = 2'd2;

	typedef enum logic [1:0] {
		SEL_ONE,
		SEL_TWO,
		SEL_NONE
	} sel_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_INPUT,
		OUT_CACHE
	} out_src_t;

	typedef enum logic [1:0] {
		ENQ_NONE,
		ENQ_INPUT,
		ENQ_CACHE,
		ENQ_LAST
	} enq_src_t;

	typedef enum logic [1:0] {
		LOCK_NONE,
		LOCK_ADD,
		LOCK_CACHE
	} lock_src_t;

	typedef enum logic [1:0] {
		CE_KEEP,
		CE_INVAL,
		CE_LOAD
	} ce_upd_t;

	typedef struct packed {
		logic iv;
		logic c1v;
		logic c2v;
		logic lv;
		logic m1;
		logic m2;
		logic il;
		logic ll;
		logic lm;
	} bcq_flags_t;

	typedef struct packed {
		sel_t      sel;
		out_src_t  out_src;
		enq_src_t  enq_src;
		lock_src_t lock_src;
		ce_upd_t   ce_upd;
		logic      deq;
	} bcq_ctrl_t;

endpackage

@@ rtl/core/bucket_collision_queue_unit.sv @@
`timescale 1ns / 1ps
// a beat is registered in the front stage, then in the step stage, then in the output register
// throughput: one beat per cycle while res_ready does not stall the output, one result beat per input beat
// the lock bit of each step's bucket is read one stage ahead, with bypass of the write
// reset: control clears at once, then every entry of the lock store is swept clear
// while in_ready stays low
module bucket_collision_queue_unit import bcq_pkg::*; #(
	parameter int unsigned BUCKET_COUNT  = BUCKET_COUNT_DEF,
	parameter int unsigned RING_DEPTH    = RING_DEPTH_DEF,
	parameter int unsigned PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               cmd,
	input  logic [BUCKET_W-1:0]      in_bucket,
	input  logic [PAYLOAD_WIDTH-1:0] in_payload,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic                     out_valid,
	output logic [BUCKET_W-1:0]      out_bucket,
	output logic [PAYLOAD_WIDTH-1:0] out_payload,
	output logic [5:0]               occupancy,
	output logic                     full_res,
	output logic                     overflow
);

	localparam int unsigned AW = $clog2(BUCKET_COUNT);
	localparam int unsigned RA = $clog2(RING_DEPTH);
	localparam int unsigned CW = $clog2(RING_DEPTH + 1);
	localparam int unsigned EW = BUCKET_W + PAYLOAD_WIDTH + AW;

	// front stage
	logic                     s1_valid;
	logic [1:0]               s1_cmd;
	logic [BUCKET_W-1:0]      s1_bucket;
	logic [PAYLOAD_WIDTH-1:0] s1_payload;
	logic [AW-1:0]            s1_laddr;
	logic                     adv12;

	// lock store sweep
	logic          clr_active_q;
	logic [AW-1:0] clr_cnt_q;

	// step stage
	logic                     s2_valid_q;
	logic [1:0]               cmd_s2;
	logic [BUCKET_W-1:0]      bucket_s2;
	logic [PAYLOAD_WIDTH-1:0] payload_s2;
	logic [AW-1:0]            laddr_s2;
	logic                     fwda_hit_s2;
	logic                     fwda_val_s2;
	logic                     s2_proc;
	logic                     is_unlock;
	logic                     upd;

	// lock store ports
	logic          lock_we;
	logic [AW-1:0] lock_waddr;
	logic          lock_wdata;
	logic          locka_rd;
	logic          lockb_rd;
	logic          fwdb_hit_q;
	logic          fwdb_val_q;
	logic          lock_in;
	logic          lock_last;

	// cache entries and last dequeued
	logic                     c_v_q [2];
	logic [BUCKET_W-1:0]      c_b_q [2];
	logic [PAYLOAD_WIDTH-1:0] c_p_q [2];
	logic [AW-1:0]            c_a_q [2];
	logic                     c_v_d [2];
	logic [BUCKET_W-1:0]      c_b_d [2];
	logic [PAYLOAD_WIDTH-1:0] c_p_d [2];
	logic [AW-1:0]            c_a_d [2];
	logic                     l_v_q;
	logic [BUCKET_W-1:0]      l_b_q;
	logic [PAYLOAD_WIDTH-1:0] l_p_q;
	logic [AW-1:0]            l_a_q;
	logic                     l_v_d;
	logic [BUCKET_W-1:0]      l_b_d;
	logic [PAYLOAD_WIDTH-1:0] l_p_d;
	logic [AW-1:0]            l_a_d;

	// ring
	logic [RA-1:0] head_q;
	logic [RA-1:0] tail_q;
	logic [CW-1:0] cnt_q;
	logic [RA-1:0] head_d;
	logic [RA-1:0] tail_d;
	logic [CW-1:0] cnt_d;
	logic          ring_we;
	logic [EW-1:0] enq_data;
	logic          enq_en;
	logic [EW-1:0] ring_rd_raw;
	logic          ring_fwd_hit_q;
	logic [EW-1:0] ring_fwd_val_q;
	logic [EW-1:0] ring_rd;

	// decision
	bcq_flags_t flags;
	bcq_ctrl_t  ctrl;
	logic       sidx;

	// result
	logic                     res_v;
	logic [BUCKET_W-1:0]      res_b;
	logic [PAYLOAD_WIDTH-1:0] res_p;
	logic                     ovf;
	logic [OCC_W-1:0]         occ;

	// output register
	logic                     res_valid_s3;
	logic                     out_valid_s3;
	logic [BUCKET_W-1:0]      out_bucket_s3;
	logic [PAYLOAD_WIDTH-1:0] out_payload_s3;
	logic [5:0]               occupancy_s3;
	logic                     full_res_s3;
	logic                     overflow_s3;

	bcq_front #(
		.BUCKET_COUNT (BUCKET_COUNT),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (!clr_active_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.in_bucket (in_bucket),
		.in_payload(in_payload),
		.take      (adv12),
		.s1_valid  (s1_valid),
		.s1_cmd    (s1_cmd),
		.s1_bucket (s1_bucket),
		.s1_payload(s1_payload),
		.s1_laddr  (s1_laddr)
	);

	assign s2_proc   = s2_valid_q && (!res_valid_s3 || res_ready);
	assign adv12     = s1_valid && (!s2_valid_q || s2_proc);
	assign is_unlock = (cmd_s2 == CMD_UNLOCK);
	assign upd       = s2_proc && !is_unlock;

	// two copies of the lock store, one read port each
	bcq_ram #(
		.WIDTH(1),
		.DEPTH(BUCKET_COUNT)
	) u_lock_a (
		.clk  (clk),
		.we   (lock_we),
		.waddr(lock_waddr),
		.wdata(lock_wdata),
		.re   (adv12),
		.raddr(s1_laddr),
		.rdata(locka_rd)
	);

	bcq_ram #(
		.WIDTH(1),
		.DEPTH(BUCKET_COUNT)
	) u_lock_b (
		.clk  (clk),
		.we   (lock_we),
		.waddr(lock_waddr),
		.wdata(lock_wdata),
		.re   (1'b1),
		.raddr(l_a_d),
		.rdata(lockb_rd)
	);

	bcq_ram #(
		.WIDTH(EW),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(head_q),
		.wdata(enq_data),
		.re   (1'b1),
		.raddr(tail_d),
		.rdata(ring_rd_raw)
	);

	assign lock_in   = fwda_hit_s2 ? fwda_val_s2 : locka_rd;
	assign lock_last = fwdb_hit_q ? fwdb_val_q : lockb_rd;
	assign ring_rd   = ring_fwd_hit_q ? ring_fwd_val_q : ring_rd_raw;

	always_comb begin
		flags     = '0;
		flags.iv  = (cmd_s2 == CMD_ADD);
		flags.c1v = c_v_q[0];
		flags.c2v = c_v_q[1];
		flags.lv  = l_v_q;
		flags.m1  = flags.iv && c_v_q[0] && (bucket_s2 == c_b_q[0]);
		flags.m2  = flags.iv && c_v_q[1] && (bucket_s2 == c_b_q[1]);
		flags.il  = flags.iv && lock_in;
		flags.ll  = l_v_q && lock_last;
		flags.lm  = l_v_q && ((flags.iv && l_b_q == bucket_s2) ||
			(c_v_q[0] && l_b_q == c_b_q[0]) || (c_v_q[1] && l_b_q == c_b_q[1]));
	end

	bcq_decide u_decide (
		.flags(flags),
		.ctrl (ctrl)
	);

	assign sidx = (ctrl.sel == SEL_TWO);

	always_comb begin
		res_v = 1'b0;
		res_b = '0;
		res_p = '0;
		if (!is_unlock) begin
			case (ctrl.out_src)
				OUT_INPUT: begin
					res_v = 1'b1;
					res_b = bucket_s2;
					res_p = payload_s2;
				end
				OUT_CACHE: begin
					res_v = 1'b1;
					res_b = c_b_q[sidx];
					res_p = c_p_q[sidx];
				end
				default: begin
					res_v = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		case (ctrl.enq_src)
			ENQ_INPUT: enq_data = {bucket_s2, payload_s2, laddr_s2};
			ENQ_CACHE: enq_data = {c_b_q[sidx], c_p_q[sidx], c_a_q[sidx]};
			ENQ_LAST:  enq_data = {l_b_q, l_p_q, l_a_q};
			default:   enq_data = '0;
		endcase
	end

	assign enq_en = (ctrl.enq_src != ENQ_NONE);

	always_comb begin
		lock_we    = 1'b0;
		lock_waddr = laddr_s2;
		lock_wdata = 1'b0;
		if (clr_active_q) begin
			lock_we    = 1'b1;
			lock_waddr = clr_cnt_q;
		end else if (s2_proc && is_unlock) begin
			lock_we = 1'b1;
		end else if (upd && ctrl.lock_src == LOCK_ADD) begin
			lock_we    = 1'b1;
			lock_wdata = 1'b1;
		end else if (upd && ctrl.lock_src == LOCK_CACHE) begin
			lock_we    = 1'b1;
			lock_waddr = c_a_q[sidx];
			lock_wdata = 1'b1;
		end
	end

	// next state: cache update, dequeue into last, then enqueue
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			c_v_d[i] = c_v_q[i];
			c_b_d[i] = c_b_q[i];
			c_p_d[i] = c_p_q[i];
			c_a_d[i] = c_a_q[i];
		end
		l_v_d   = l_v_q;
		l_b_d   = l_b_q;
		l_p_d   = l_p_q;
		l_a_d   = l_a_q;
		head_d  = head_q;
		tail_d  = tail_q;
		cnt_d   = cnt_q;
		ring_we = 1'b0;
		ovf     = 1'b0;

		if (upd) begin
			if (ctrl.sel != SEL_NONE) begin
				if (ctrl.ce_upd == CE_LOAD) begin
					c_v_d[sidx] = l_v_q;
					c_b_d[sidx] = l_b_q;
					c_p_d[sidx] = l_p_q;
					c_a_d[sidx] = l_a_q;
				end else if (ctrl.ce_upd == CE_INVAL) begin
					c_v_d[sidx] = 1'b0;
				end
			end

			if (ctrl.deq) begin
				if (cnt_q != '0) begin
					l_v_d                = 1'b1;
					{l_b_d, l_p_d, l_a_d} = ring_rd;
					tail_d = (tail_q == RA'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
					cnt_d  = cnt_q - 1'b1;
				end else begin
					l_v_d = 1'b0;
				end
			end

			if (enq_en) begin
				if (cnt_d == CW'(RING_DEPTH)) begin
					ovf = 1'b1;
				end else begin
					ring_we = 1'b1;
					head_d  = (head_q == RA'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
					cnt_d   = cnt_d + 1'b1;
				end
			end
		end
	end

	assign occ = OCC_W'(c_v_d[0]) + OCC_W'(c_v_d[1]) + OCC_W'(l_v_d) + OCC_W'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q   <= 1'b1;
			clr_cnt_q      <= '0;
			s2_valid_q     <= 1'b0;
			fwda_hit_s2    <= 1'b0;
			fwdb_hit_q     <= 1'b0;
			ring_fwd_hit_q <= 1'b0;
			c_v_q[0]       <= 1'b0;
			c_v_q[1]       <= 1'b0;
			l_v_q          <= 1'b0;
			head_q         <= '0;
			tail_q         <= '0;
			cnt_q          <= '0;
			res_valid_s3   <= 1'b0;
		end else begin
			if (clr_active_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == AW'(BUCKET_COUNT - 1)) begin
					clr_active_q <= 1'b0;
				end
			end

			if (adv12) begin
				s2_valid_q  <= 1'b1;
				fwda_hit_s2 <= lock_we && (lock_waddr == s1_laddr);
			end else if (s2_proc) begin
				s2_valid_q <= 1'b0;
			end

			// bypass the write that lands in the same cycle as the read
			fwdb_hit_q     <= lock_we && (lock_waddr == l_a_d);
			ring_fwd_hit_q <= ring_we && (head_q == tail_d);

			c_v_q[0] <= c_v_d[0];
			c_v_q[1] <= c_v_d[1];
			l_v_q    <= l_v_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			cnt_q    <= cnt_d;

			if (s2_proc) begin
				res_valid_s3 <= 1'b1;
			end else if (res_ready) begin
				res_valid_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv12) begin
			cmd_s2      <= s1_cmd;
			bucket_s2   <= s1_bucket;
			payload_s2  <= s1_payload;
			laddr_s2    <= s1_laddr;
			fwda_val_s2 <= lock_wdata;
		end
		fwdb_val_q     <= lock_wdata;
		ring_fwd_val_q <= enq_data;
		for (int i = 0; i < 2; i++) begin
			c_b_q[i] <= c_b_d[i];
			c_p_q[i] <= c_p_d[i];
			c_a_q[i] <= c_a_d[i];
		end
		l_b_q <= l_b_d;
		l_p_q <= l_p_d;
		l_a_q <= l_a_d;
		if (s2_proc) begin
			out_valid_s3   <= res_v;
			out_bucket_s3  <= res_b;
			out_payload_s3 <= res_p;
			occupancy_s3   <= occ[5:0];
			full_res_s3    <= (occ == OCC_W'(RING_DEPTH));
			overflow_s3    <= ovf;
		end
	end

	assign res_valid   = res_valid_s3;
	assign out_valid   = out_valid_s3;
	assign out_bucket  = out_bucket_s3;
	assign out_payload = out_payload_s3;
	assign occupancy   = occupancy_s3;
	assign full_res    = full_res_s3;
	assign overflow    = overflow_s3;

endmodule

@@ rtl/core/bcq_ram.sv @@
`timescale 1ns / 1ps

module bcq_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 2,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/bcq_front.sv @@
`timescale 1ns / 1ps

module bcq_front import bcq_pkg::*; #(
	parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF,
	parameter int unsigned PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
	localparam int unsigned AW = $clog2(BUCKET_COUNT)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               cmd,
	input  logic [BUCKET_W-1:0]      in_bucket,
	input  logic [PAYLOAD_WIDTH-1:0] in_payload,
	input  logic                     take,
	output logic                     s1_valid,
	output logic [1:0]               s1_cmd,
	output logic [BUCKET_W-1:0]      s1_bucket,
	output logic [PAYLOAD_WIDTH-1:0] s1_payload,
	output logic [AW-1:0]            s1_laddr
);

	logic                     valid_s1;
	logic [1:0]               cmd_s1;
	logic [BUCKET_W-1:0]      bucket_s1;
	logic [PAYLOAD_WIDTH-1:0] payload_s1;
	logic                     load;

	assign in_ready = en && (!valid_s1 || take);
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1     <= cmd;
			bucket_s1  <= in_bucket;
			payload_s1 <= in_payload;
		end
	end

	// lock address is bucket modulo the bucket count
	generate
		if (BUCKET_COUNT >= 8192) begin : g_direct
			assign s1_laddr = AW'(bucket_s1);
		end else begin : g_mod
			// quotient estimate by reciprocal, low by at most one
			localparam int unsigned MUL = (1 << 26) / BUCKET_COUNT;
			logic [38:0]         prod;
			logic [BUCKET_W-1:0] qest_s1;
			logic [25:0]         qn;
			logic [BUCKET_W-1:0] rest;
			logic [BUCKET_W-1:0] rfix;

			assign prod = 39'(in_bucket) * 39'(MUL);

			always_ff @(posedge clk) begin
				if (load) begin
					qest_s1 <= prod[38:26];
				end
			end

			assign qn   = 26'(qest_s1) * 26'(BUCKET_COUNT);
			assign rest = bucket_s1 - qn[BUCKET_W-1:0];
			assign rfix = (rest >= BUCKET_W'(BUCKET_COUNT)) ?
				rest - BUCKET_W'(BUCKET_COUNT) : rest;
			assign s1_laddr = rfix[AW-1:0];
		end
	endgenerate

	assign s1_valid   = valid_s1;
	assign s1_cmd     = cmd_s1;
	assign s1_bucket  = bucket_s1;
	assign s1_payload = payload_s1;

endmodule

@@ rtl/core/bcq_decide.sv @@
`timescale 1ns / 1ps

module bcq_decide import bcq_pkg::*; (
	input  bcq_flags_t flags,
	output bcq_ctrl_t  ctrl
);

	logic last_free;

	assign last_free = flags.lv && !flags.ll && !flags.lm;

	always_comb begin
		ctrl          = '0;
		ctrl.sel      = SEL_NONE;
		ctrl.out_src  = OUT_NONE;
		ctrl.enq_src  = ENQ_NONE;
		ctrl.lock_src = LOCK_NONE;
		ctrl.ce_upd   = CE_KEEP;
		ctrl.deq      = 1'b0;

		if (flags.iv && !flags.il) begin
			// free addition goes out; a cache entry on the same bucket is pushed back
			ctrl.out_src  = OUT_INPUT;
			ctrl.lock_src = LOCK_ADD;
			if (flags.m1) begin
				ctrl.sel     = SEL_ONE;
				ctrl.enq_src = ENQ_CACHE;
			end else if (flags.m2) begin
				ctrl.sel     = SEL_TWO;
				ctrl.enq_src = ENQ_CACHE;
			end
		end else begin
			ctrl.enq_src = flags.iv ? ENQ_INPUT : ENQ_NONE;
			if (flags.c1v) begin
				ctrl.out_src  = OUT_CACHE;
				ctrl.sel      = SEL_ONE;
				ctrl.lock_src = LOCK_CACHE;
			end else if (flags.c2v) begin
				ctrl.out_src  = OUT_CACHE;
				ctrl.sel      = SEL_TWO;
				ctrl.lock_src = LOCK_CACHE;
			end
		end

		if (ctrl.sel == SEL_NONE) begin
			if (!flags.c1v && last_free) begin
				ctrl.sel    = SEL_ONE;
				ctrl.ce_upd = CE_LOAD;
				ctrl.deq    = 1'b1;
			end else if (!flags.c2v && last_free) begin
				ctrl.sel    = SEL_TWO;
				ctrl.ce_upd = CE_LOAD;
				ctrl.deq    = 1'b1;
			end
		end else if (last_free) begin
			ctrl.ce_upd = CE_LOAD;
			ctrl.deq    = 1'b1;
		end else begin
			ctrl.ce_upd = CE_INVAL;
		end

		// blocked last entry recycles to the ring while a cache slot is open
		if (!flags.lv) begin
			ctrl.deq = 1'b1;
		end else if (ctrl.enq_src == ENQ_NONE && (flags.ll || flags.lm) &&
				(!flags.c1v || !flags.c2v)) begin
			ctrl.enq_src = ENQ_LAST;
			ctrl.deq     = 1'b1;
		end
	end

endmodule
